/* design/id3x_pkg.sv */
package id3x_pkg;

  localparam int unsigned HeaderSize = 10;
  localparam int unsigned KeyBytes   = 4;
  localparam int unsigned SizeBytes  = 4;
  localparam int unsigned FlagBytes  = 2;
  localparam int unsigned MagicBytes = 3;

  localparam logic [23:0] MAGIC_ID3 = 24'h494433;
  localparam logic [31:0] KEY_TIT2  = 32'h54495432;
  localparam logic [31:0] KEY_TPE1  = 32'h54504531;
  localparam logic [3:0]  WANTED_RESET = 4'd2;

  localparam logic [1:0] CFG_FIRST_KEY    = 2'd0;
  localparam logic [1:0] CFG_SECOND_KEY   = 2'd1;
  localparam logic [1:0] CFG_WANTED_COUNT = 2'd2;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;
  localparam logic [1:0] MATCH_NONE  = 2'd3;

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_HDRSKIP = 3'd1;
  localparam logic [2:0] PH_KEY     = 3'd2;
  localparam logic [2:0] PH_SIZE    = 3'd3;
  localparam logic [2:0] PH_FLAGS   = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_BODY    = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  typedef struct packed {
    logic [31:0] first_key;
    logic [31:0] second_key;
    logic [3:0]  wanted_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
  } word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] text_byte;
    logic       text_valid;
    logic       last_of_field;
    logic       all_found;
  } res_t;

endpackage

/* design/id3x_cfg.sv */
module id3x_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output id3x_pkg::cfg_t cfg_o
);
  import id3x_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_KEY:    cfg_d.first_key    = cfg_data_i;
        CFG_SECOND_KEY:   cfg_d.second_key   = cfg_data_i;
        CFG_WANTED_COUNT: cfg_d.wanted_count = cfg_data_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_key    <= KEY_TIT2;
      cfg_q.second_key   <= KEY_TPE1;
      cfg_q.wanted_count <= WANTED_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/id3x_in.sv */
module id3x_in (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            first_of_file_i,
  output logic            word_valid_o,
  output id3x_pkg::word_t word_o,
  input  logic            step_i
);
  import id3x_pkg::*;

  logic  valid_q;
  logic  valid_d;
  word_t word_q;
  logic  accept;

  assign in_stall_o   = valid_q & ~step_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign word_valid_o = valid_q;
  assign word_o       = word_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.data_byte     <= data_byte_i;
      word_q.first_of_file <= first_of_file_i;
    end
  end

endmodule

/* design/id3x_parse.sv */
module id3x_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  id3x_pkg::word_t word_i,
  input  id3x_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output id3x_pkg::res_t  res_o
);
  import id3x_pkg::*;

  logic [2:0]  phase_q, phase_d, cur_phase;
  logic [3:0]  pos_q, pos_d, cur_pos;
  logic [31:0] key_q, key_d, cur_key;
  logic [31:0] size_q, size_d, cur_size;
  logic [31:0] rem_q, rem_d, cur_rem;
  logic [1:0]  match_q, match_d, cur_match;
  logic [3:0]  found_q, found_d, cur_found;
  logic        term_q, term_d, cur_term;

  logic [3:0]  pos_inc;
  logic [31:0] key_shl;
  logic [31:0] rem_dec;
  logic [31:0] skip_rem;
  logic [3:0]  want;
  logic [3:0]  fin_found;
  logic        fin_all;
  logic        byte_nz;
  logic        body_valid;
  logic        body_last;

  always_comb begin
    if (word_i.first_of_file) begin
      cur_phase = PH_MAGIC;
      cur_pos   = '0;
      cur_key   = '0;
      cur_size  = '0;
      cur_rem   = '0;
      cur_match = MATCH_NONE;
      cur_found = '0;
      cur_term  = 1'b0;
    end else begin
      cur_phase = phase_q;
      cur_pos   = pos_q;
      cur_key   = key_q;
      cur_size  = size_q;
      cur_rem   = rem_q;
      cur_match = match_q;
      cur_found = found_q;
      cur_term  = term_q;
    end
  end

  assign pos_inc    = cur_pos + 4'd1;
  assign key_shl    = {cur_key[23:0], word_i.data_byte};
  assign rem_dec    = cur_rem - 32'd1;
  assign skip_rem   = (cur_size != '0) ? cur_size - 32'd1 : '0;
  assign want       = (cfg_i.wanted_count != '0) ? cfg_i.wanted_count : 4'd1;
  assign byte_nz    = word_i.data_byte != 8'd0;
  assign body_valid = ~cur_term & byte_nz;
  assign body_last  = rem_dec == '0;

  always_comb begin
    fin_found = cur_found;
    fin_all   = 1'b0;
    if (cur_match != MATCH_NONE) begin
      if (cur_found != 4'hF) begin
        fin_found = cur_found + 4'd1;
      end
      fin_all = fin_found >= want;
    end
  end

  always_comb begin
    phase_d     = cur_phase;
    pos_d       = cur_pos;
    key_d       = cur_key;
    size_d      = cur_size;
    rem_d       = cur_rem;
    match_d     = cur_match;
    found_d     = cur_found;
    term_d      = cur_term;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (cur_phase)
      PH_MAGIC: begin
        key_d = key_shl;
        pos_d = pos_inc;
        if (pos_inc >= 4'(MagicBytes)) begin
          if (key_shl[23:0] != MAGIC_ID3) begin
            phase_d           = PH_DONE;
            res_valid_o       = 1'b1;
            res_o.result_kind = KIND_BAD;
          end else begin
            phase_d = PH_HDRSKIP;
          end
        end
      end
      PH_HDRSKIP: begin
        pos_d = pos_inc;
        if (pos_inc >= 4'(HeaderSize)) begin
          phase_d = PH_KEY;
          pos_d   = '0;
          key_d   = '0;
        end
      end
      PH_KEY: begin
        key_d = key_shl;
        pos_d = pos_inc;
        if (pos_inc >= 4'(KeyBytes)) begin
          if (key_shl == cfg_i.first_key) begin
            match_d = KIND_FIRST;
          end else if (key_shl == cfg_i.second_key) begin
            match_d = KIND_SECOND;
          end else begin
            match_d = MATCH_NONE;
          end
          phase_d = PH_SIZE;
          pos_d   = '0;
          size_d  = '0;
        end
      end
      PH_SIZE: begin
        size_d = {cur_size[23:0], word_i.data_byte};
        pos_d  = pos_inc;
        if (pos_inc >= 4'(SizeBytes)) begin
          phase_d = PH_FLAGS;
          pos_d   = '0;
        end
      end
      PH_FLAGS: begin
        pos_d = pos_inc;
        if (pos_inc >= 4'(FlagBytes)) begin
          phase_d = PH_SKIP;
          pos_d   = '0;
        end
      end
      PH_SKIP: begin
        rem_d  = skip_rem;
        term_d = 1'b0;
        if (skip_rem == '0) begin
          found_d = fin_found;
          pos_d   = '0;
          if (fin_all) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_KEY;
            key_d   = '0;
          end
          if (cur_match != MATCH_NONE) begin
            res_valid_o         = 1'b1;
            res_o.result_kind   = cur_match;
            res_o.last_of_field = 1'b1;
            res_o.all_found     = fin_all;
          end
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        rem_d = rem_dec;
        if (!byte_nz) begin
          term_d = 1'b1;
        end
        if (body_last) begin
          found_d = fin_found;
          pos_d   = '0;
          if (fin_all) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_KEY;
            key_d   = '0;
          end
        end
        if (cur_match != MATCH_NONE && (body_valid || body_last)) begin
          res_valid_o         = 1'b1;
          res_o.result_kind   = cur_match;
          res_o.text_byte     = body_valid ? word_i.data_byte : 8'd0;
          res_o.text_valid    = body_valid;
          res_o.last_of_field = body_last;
          res_o.all_found     = body_last & fin_all;
        end
      end
      default: begin
        phase_d = cur_phase;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      pos_q   <= '0;
      key_q   <= '0;
      size_q  <= '0;
      rem_q   <= '0;
      match_q <= MATCH_NONE;
      found_q <= '0;
      term_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      key_q   <= key_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
      match_q <= match_d;
      found_q <= found_d;
      term_q  <= term_d;
    end
  end

endmodule

/* design/id3x_out.sv */
module id3x_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           res_valid_i,
  input  id3x_pkg::res_t res_i,
  output logic           out_ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output id3x_pkg::res_t res_o
);
  import id3x_pkg::*;

  logic valid_q;
  logic valid_d;
  res_t res_q;

  assign out_ready_o = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = res_valid_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* design/id3v2_text_frame_extractor.sv */
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i / in_stall_o  data_byte_i, first_of_file_i
// out       source     out_valid_o / out_stall_i result_kind_o, text_byte_o, text_valid_o,
//                                               last_of_field_o, all_found_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle sustained unless the output stalls; a word moves through the input
// register, one pass of the frame parser and the result register.
// Reset clears the parser to the magic check and loads keys TIT2 / TPE1, wanted count 2.
// A stall on the output holds the result register and, once the input register is also
// full, raises in_stall_o; cfg_ready_o is always high.
module id3v2_text_frame_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  text_byte_o,
  output logic        text_valid_o,
  output logic        last_of_field_o,
  output logic        all_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import id3x_pkg::*;

  cfg_t  cfg;
  word_t word;
  res_t  res;
  res_t  res_out;
  logic  word_valid;
  logic  res_valid;
  logic  out_ready;
  logic  step;

  assign step = word_valid & out_ready;

  id3x_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  id3x_in u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .first_of_file_i (first_of_file_i),
    .word_valid_o    (word_valid),
    .word_o          (word),
    .step_i          (step)
  );

  id3x_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (word),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  id3x_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign result_kind_o   = res_out.result_kind;
  assign text_byte_o     = res_out.text_byte;
  assign text_valid_o    = res_out.text_valid;
  assign last_of_field_o = res_out.last_of_field;
  assign all_found_o     = res_out.all_found;

endmodule

/* tb/id3_text_checker.sv */
module id3_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_of_file_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [7:0]  text_byte_i,
  input  logic        text_valid_i,
  input  logic        last_of_field_i,
  input  logic        all_found_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import id3x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] key_a;
  logic [31:0] key_b;
  logic [3:0]  want_n;

  logic [2:0]  ph;
  logic [3:0]  pos;
  logic [31:0] key_acc;
  logic [31:0] size_acc;
  logic [31:0] body_left;
  logic [1:0]  hit_kind;
  logic [3:0]  hit_count;
  logic        zero_seen;

  res_t        due_results_q[$];
  res_t        head;
  int unsigned errors = 0;
  int unsigned checked = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic clear_parse();
    ph = PH_MAGIC;
    pos = '0;
    key_acc = '0;
    size_acc = '0;
    body_left = '0;
    hit_kind = MATCH_NONE;
    hit_count = '0;
    zero_seen = 1'b0;
  endtask

  // close the frame; stop parsing once enough matches are in
  task automatic close_frame(output logic reached);
    logic [3:0] need;
    reached = 1'b0;
    if (hit_kind != MATCH_NONE) begin
      need = (want_n == 4'd0) ? 4'd1 : want_n;
      if (hit_count < 4'd15) hit_count++;
      reached = (hit_count >= need);
    end
    if (reached) begin
      ph = PH_DONE;
    end else begin
      ph = PH_KEY;
      key_acc = '0;
    end
    pos = '0;
  endtask

  task automatic parse_file_byte(input logic [7:0] b, input logic fof);
    res_t       r;
    logic       reached;
    logic       is_last;
    logic       is_text;
    logic [1:0] kind;
    r = '0;
    reached = 1'b0;
    if (fof) clear_parse();
    case (ph)
      PH_MAGIC: begin
        key_acc = {key_acc[23:0], b};
        pos++;
        if (pos >= MagicBytes) begin
          if (key_acc[23:0] != MAGIC_ID3) begin
            ph = PH_DONE;
            r.result_kind = KIND_BAD;
            due_results_q.push_back(r);
          end else begin
            ph = PH_HDRSKIP;
          end
        end
      end
      PH_HDRSKIP: begin
        pos++;
        if (pos >= HeaderSize) begin
          ph = PH_KEY;
          pos = '0;
          key_acc = '0;
        end
      end
      PH_KEY: begin
        key_acc = {key_acc[23:0], b};
        pos++;
        if (pos >= KeyBytes) begin
          if (key_acc == key_a) hit_kind = KIND_FIRST;
          else if (key_acc == key_b) hit_kind = KIND_SECOND;
          else hit_kind = MATCH_NONE;
          ph = PH_SIZE;
          pos = '0;
          size_acc = '0;
        end
      end
      PH_SIZE: begin
        size_acc = {size_acc[23:0], b};
        pos++;
        if (pos >= SizeBytes) begin
          ph = PH_FLAGS;
          pos = '0;
        end
      end
      PH_FLAGS: begin
        pos++;
        if (pos >= FlagBytes) begin
          ph = PH_SKIP;
          pos = '0;
        end
      end
      PH_SKIP: begin
        body_left = (size_acc != 0) ? size_acc - 32'd1 : 32'd0;
        zero_seen = 1'b0;
        if (body_left == 0) begin
          kind = hit_kind;
          close_frame(reached);
          if (kind != MATCH_NONE) begin
            r.result_kind = kind;
            r.last_of_field = 1'b1;
            r.all_found = reached;
            due_results_q.push_back(r);
          end
        end else begin
          ph = PH_BODY;
        end
      end
      PH_BODY: begin
        body_left--;
        is_last = (body_left == 0);
        kind = hit_kind;
        is_text = !zero_seen && (b != 8'h00);
        if (b == 8'h00) zero_seen = 1'b1;
        if (is_last) close_frame(reached);
        if (kind != MATCH_NONE && (is_text || is_last)) begin
          r.result_kind = kind;
          r.text_byte = is_text ? b : 8'h00;
          r.text_valid = is_text;
          r.last_of_field = is_last;
          r.all_found = reached;
          due_results_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a = KEY_TIT2;
      key_b = KEY_TPE1;
      want_n = WANTED_RESET;
      clear_parse();
      due_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (due_results_q.size() == 0) begin
          report_mismatch("result word with none due", {result_kind_i, text_byte_i}, '0);
        end else begin
          head = due_results_q.pop_front();
          if (result_kind_i !== head.result_kind)
            report_mismatch("result_kind", result_kind_i, head.result_kind);
          if (text_byte_i !== head.text_byte)
            report_mismatch("text_byte", text_byte_i, head.text_byte);
          if (text_valid_i !== head.text_valid)
            report_mismatch("text_valid", text_valid_i, head.text_valid);
          if (last_of_field_i !== head.last_of_field)
            report_mismatch("last_of_field", last_of_field_i, head.last_of_field);
          if (all_found_i !== head.all_found)
            report_mismatch("all_found", all_found_i, head.all_found);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIRST_KEY:    key_a = cfg_data_i;
          CFG_SECOND_KEY:   key_b = cfg_data_i;
          CFG_WANTED_COUNT: want_n = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) parse_file_byte(data_byte_i, first_of_file_i);
    end
    pending_o <= due_results_q.size();
    error_count_o <= errors;
    checked_o <= checked;
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import id3x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_of_file;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  result_kind;
  logic [7:0]  text_byte;
  logic        text_valid;
  logic        last_of_field;
  logic        all_found;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;

  word_t       file_bytes_q[$];
  logic [31:0] reg_first = KEY_TIT2;
  logic [31:0] reg_second = KEY_TPE1;
  logic [3:0]  reg_want = WANTED_RESET;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_given = 0;
  int unsigned bytes_sent = 0;
  int unsigned files = 0;
  int unsigned settings = 1;
  int unsigned quiet;
  int unsigned p;

  id3v2_text_frame_extractor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .first_of_file_i (first_of_file),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind),
    .text_byte_o     (text_byte),
    .text_valid_o    (text_valid),
    .last_of_field_o (last_of_field),
    .all_found_o     (all_found),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  id3_text_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .first_of_file_i (first_of_file),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_i   (result_kind),
    .text_byte_i     (text_byte),
    .text_valid_i    (text_valid),
    .last_of_field_i (last_of_field),
    .all_found_i     (all_found),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic put(input logic [7:0] b, input logic fof);
    word_t w;
    w.data_byte = b;
    w.first_of_file = fof;
    file_bytes_q.push_back(w);
  endtask

  task automatic put_header(input logic [23:0] magic, input logic fof);
    files++;
    put(magic[23:16], fof);
    put(magic[15:8], 1'b0);
    put(magic[7:0], 1'b0);
    if (magic == MAGIC_ID3) repeat (HeaderSize - MagicBytes) put(8'($urandom), 1'b0);
  endtask

  task automatic put_frame(input logic [31:0] key, input logic [31:0] size,
                           input int unsigned body_n);
    int i;
    for (i = 3; i >= 0; i--) put(key[8*i +: 8], 1'b0);
    for (i = 3; i >= 0; i--) put(size[8*i +: 8], 1'b0);
    repeat (FlagBytes + 1) put(8'($urandom), 1'b0);
    repeat (body_n) put(($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255, 1)), 1'b0);
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return reg_first;
    if (r < 70) return reg_second;
    if (r < 85) return ((r < 78) ? reg_first : reg_second) ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  task automatic put_random_file();
    int unsigned roll;
    int unsigned frames;
    int unsigned f;
    int unsigned start;
    int unsigned added;
    logic [23:0] magic;
    logic [31:0] size;
    roll = $urandom_range(99);
    if (roll < 10) begin
      magic = (roll < 5) ? (MAGIC_ID3 ^ (24'd1 << $urandom_range(23))) : 24'($urandom);
      if (magic == MAGIC_ID3) magic[0] = ~magic[0];
      put_header(magic, 1'b1);
      repeat ($urandom_range(4)) put(8'($urandom), 1'b0);
    end else begin
      put_header(MAGIC_ID3, 1'b1);
      frames = (roll < 15) ? $urandom_range(20, 16) : $urandom_range(6, 1);
      for (f = 0; f < frames; f++) begin
        start = file_bytes_q.size();
        if ($urandom_range(99) < 3) begin
          // oversized frame: cut the file short inside its body
          put_frame(pick_key(), $urandom | 32'h0100_0000, $urandom_range(6));
          break;
        end
        if (roll < 15) size = $urandom_range(2);
        else if ($urandom_range(99) < 90) size = $urandom_range(8);
        else size = $urandom_range(40, 9);
        put_frame(pick_key(), size, (size > 1) ? size - 1 : 0);
        if (roll >= 90 && f == frames - 1) begin
          added = file_bytes_q.size() - start;
          repeat ($urandom_range(added - 1, 1)) void'(file_bytes_q.pop_back());
        end
      end
    end
  endtask

  task automatic send_file_bytes();
    word_t w;
    while (file_bytes_q.size() != 0) begin
      w = file_bytes_q.pop_front();
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
      in_valid <= 1'b1;
      data_byte <= w.data_byte;
      first_of_file <= w.first_of_file;
      do @(posedge clk_i); while (in_stall);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] k0, input logic [31:0] k1,
                              input logic [3:0] n);
    reg_first = k0;
    reg_second = k1;
    reg_want = n;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIRST_KEY;
    cfg_data <= k0;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_SECOND_KEY;
    cfg_data <= k1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CFG_WANTED_COUNT;
    cfg_data <= {28'd0, n};
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_given) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_given++;
      end else begin
        out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("id3v2_text_frame_extractor: mismatch");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    first_of_file <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FIRST_KEY;
    cfg_data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset keys; first file starts without a start-of-file flag
    put_header(MAGIC_ID3, 1'b0);
    put_frame(KEY_TIT2, 32'd5, 0);
    put(8'h48, 1'b0); put(8'h69, 1'b0); put(8'h00, 1'b0); put(8'h78, 1'b0);
    put_frame(32'h4141_4141, 32'd3, 2);
    put_frame(KEY_TPE1, 32'd0, 0);
    put(8'hFF, 1'b0); put(8'h00, 1'b0);
    put_header(24'h494458, 1'b1);
    put(8'h49, 1'b0);
    put_header(MAGIC_ID3, 1'b1);
    put_frame(KEY_TIT2, 32'd1, 0);
    put_frame(KEY_TPE1, 32'd3, 0);
    put(8'hFF, 1'b0); put(8'h00, 1'b0);
    put_header(MAGIC_ID3, 1'b1);
    put_frame(KEY_TIT2, 32'hFFFF_FFFF, 0);
    put(8'hFF, 1'b0); put(8'h01, 1'b0); put(8'h00, 1'b0); put(8'h80, 1'b0);
    put_header(24'h4A4433, 1'b1);
    send_file_bytes();
    settle();

    // equal keys at the top of the range, wanted count of zero
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    put_header(MAGIC_ID3, 1'b1);
    put_frame(32'hFFFF_FFFF, 32'd2, 0);
    put(8'h5A, 1'b0);
    put_frame(32'hFFFF_FFFF, 32'd0, 0);
    send_file_bytes();
    settle();

    // swap keys part way through one file
    program_regs(32'h0000_0000, 32'h0000_0001, 4'd15);
    put_header(MAGIC_ID3, 1'b1);
    put_frame(32'h0000_0000, 32'd2, 0);
    put(8'h61, 1'b0);
    put_frame(32'h0000_0001, 32'd1, 0);
    send_file_bytes();
    settle();
    program_regs(32'h0000_0001, 32'h0000_0000, 4'd15);
    put_frame(32'h0000_0000, 32'd2, 0);
    put(8'h62, 1'b0);
    put_frame(32'h0000_0001, 32'd0, 0);
    send_file_bytes();
    settle();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(KEY_TIT2, KEY_TPE1, WANTED_RESET);
        1: program_regs($urandom, $urandom, 4'd15);
        2: program_regs($urandom, $urandom, 4'd1);
        3: program_regs(32'h0000_0000, 32'hFFFF_FFFF, 4'($urandom_range(15, 1)));
        6: begin
          reg_first = $urandom;
          program_regs(reg_first, reg_first, 4'($urandom_range(15, 1)));
        end
        default: program_regs($urandom, $urandom, 4'($urandom_range(15, 1)));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (p == 0) hold_asked++;
      while (file_bytes_q.size() < 24) put_random_file();
      send_file_bytes();
      settle();
    end

    $display("Sent %0d bytes in %0d files under %0d register settings, with mixed idle",
             bytes_sent, files, settings);
    $display("and stall rates and one long output hold-off; %0d result words compared.",
             checked);
    if (error_count == 0 && pending == 0)
      $display("id3v2_text_frame_extractor: match");
    else
      $display("id3v2_text_frame_extractor: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/id3x_pkg.sv
design/id3x_cfg.sv
design/id3x_in.sv
design/id3x_parse.sv
design/id3x_out.sv
design/id3v2_text_frame_extractor.sv
tb/id3_text_checker.sv
tb/testbench.sv
